// ===== hdl/lsa_pkg.sv =====
// Shared constants and types for the lidar sector avoidance block.
// No dependencies; imported by lidar_sector_avoidance_top.
package lsa_pkg;

  // Largest scan length the index counter is built for.
  localparam int MAX_POINTS_DEF = 4096;

  // Payload widths fixed by the interface.
  localparam int RANGE_W   = 16;
  localparam int SPEED_W   = 15;
  localparam int ANG_W     = 16;
  localparam int CODE_W    = 3;
  localparam int SCAN_W    = 13;
  localparam int FRAC_W    = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int OUT_DATA_W = 88;

  // Running minimum start value, meaning no valid return in the sector.
  localparam logic [RANGE_W-1:0] NO_RANGE = 16'd50000;

  // Configuration reset values.
  localparam logic [SCAN_W-1:0]  SCAN_POINTS_RST  = 13'd720;
  localparam logic [FRAC_W-1:0]  BACK_FRAC_RST    = 15'd15729;
  localparam logic [RANGE_W-1:0] OBSTACLE_MM_RST  = 16'd3000;
  localparam logic [RANGE_W-1:0] MIN_VALID_RST    = 16'd100;
  localparam logic [SPEED_W-1:0] CRUISE_RST       = 15'd300;
  localparam logic [SPEED_W-1:0] FALLBACK_RST     = 15'd100;
  localparam logic [SPEED_W-1:0] TURN_RATE_RST    = 15'd500;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_POINTS  = 3'd0,
    REG_BACK_FRAC    = 3'd1,
    REG_OBSTACLE_MM  = 3'd2,
    REG_MIN_VALID    = 3'd3,
    REG_CRUISE       = 3'd4,
    REG_FALLBACK     = 3'd5,
    REG_TURN_RATE    = 3'd6
  } cfg_reg_t;

  // Decision table outcomes.
  typedef enum logic [CODE_W-1:0] {
    CASE_CLEAR       = 3'd0,
    CASE_FRONT       = 3'd1,
    CASE_FRONT_LEFT  = 3'd2,
    CASE_FRONT_RIGHT = 3'd3,
    CASE_BOTH_BACK   = 3'd4,
    CASE_OTHER       = 3'd5
  } case_code_t;

endpackage

// ===== hdl/lidar_sector_avoidance_top.sv =====
// Lidar sector avoidance: per-sample sector minimum tracking and velocity decision.
// Depends on lsa_pkg.
//
// Usage:
//   The input stream carries one range sample (mm) per beat on in_tdata. The
//   block counts samples within a scan of scan_points beats. Samples update
//   the back-left, front and back-right running minimums; the last sample of
//   a scan is not tracked but produces one result beat on out_tdata holding
//   the velocity command, the decision code and the three minimums.
//   The result beat is registered and is valid the cycle after the last sample beat.
//   Throughput: one sample per clock while in_tready is high. Each beat passes through one level of
//   compares against the three minimum registers; sector limits are
//   precomputed in registers when scan_points or back_fraction_q16 is written.
//   If the receiver stalls, samples keep flowing until the last sample of the
//   next scan finds the result register still full; only then in_tready drops.
//   Reset (synchronous, rst_n low) loads the default configuration, clears
//   the sample index, sets all minimums to 50000 and empties the output.
//   The configuration port is to be written by the user only while no result is pending; the block does not enforce it.
module lidar_sector_avoidance_top #(
  parameter int MAX_POINTS = lsa_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [lsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsa_pkg::CFG_W-1:0]       cfg_wdata,
  // Sample input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lsa_pkg::RANGE_W-1:0]     in_tdata,   // [15:0] range_mm
  // Result output stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [14:0] linear_speed, [30:15] angular_speed, [33:31] case_code,
  // [49:34] min_back_left, [65:50] min_front, [81:66] min_back_right, [87:82] zero
  output logic [lsa_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import lsa_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int SIZE_W = $clog2(MAX_POINTS + 1);
  localparam int PROD_W = FRAC_W + SIZE_W;

  // Clamp a written scan length to the supported range.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SCAN_W-1:0] s);
    logic [SIZE_W-1:0] res;
    if (32'(s) > 32'(MAX_POINTS)) begin
      res = SIZE_W'(MAX_POINTS);
    end else if (s < SCAN_W'(2)) begin
      res = SIZE_W'(2);
    end else begin
      res = SIZE_W'(s);
    end
    return res;
  endfunction

  // Back sector boundary: floor(fraction * size / 65536).
  function automatic logic [SIZE_W-1:0] calc_lim(input logic [FRAC_W-1:0] f,
                                                 input logic [SIZE_W-1:0] s);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(f) * PROD_W'(s);
    return SIZE_W'(prod >> 16);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers and derived sector limits
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0]  size_r, lim_r, rlim_r, last_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [RANGE_W-1:0] obstacle_r, min_valid_r;
  logic [SPEED_W-1:0] cruise_r, fallback_r, turn_r;

  logic [SIZE_W-1:0]  size_sel, lim_nxt;
  logic [FRAC_W-1:0]  frac_sel;

  // Combine the new value with the stored partner to recompute the limits.
  always_comb begin
    size_sel = size_r;
    frac_sel = frac_r;
    if (cfg_we && cfg_index == REG_SCAN_POINTS) begin
      size_sel = clamp_size(cfg_wdata[SCAN_W-1:0]);
    end
    if (cfg_we && cfg_index == REG_BACK_FRAC) begin
      frac_sel = cfg_wdata[FRAC_W-1:0];
    end
    lim_nxt = calc_lim(frac_sel, size_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= clamp_size(SCAN_POINTS_RST);
      frac_r      <= BACK_FRAC_RST;
      lim_r       <= calc_lim(BACK_FRAC_RST, clamp_size(SCAN_POINTS_RST));
      rlim_r      <= clamp_size(SCAN_POINTS_RST)
                     - calc_lim(BACK_FRAC_RST, clamp_size(SCAN_POINTS_RST));
      last_r      <= clamp_size(SCAN_POINTS_RST) - SIZE_W'(1);
      obstacle_r  <= OBSTACLE_MM_RST;
      min_valid_r <= MIN_VALID_RST;
      cruise_r    <= CRUISE_RST;
      fallback_r  <= FALLBACK_RST;
      turn_r      <= TURN_RATE_RST;
    end else if (cfg_we) begin
      size_r <= size_sel;
      frac_r <= frac_sel;
      lim_r  <= lim_nxt;
      rlim_r <= size_sel - lim_nxt;
      last_r <= size_sel - SIZE_W'(1);
      case (cfg_index)
        REG_OBSTACLE_MM: obstacle_r  <= cfg_wdata[RANGE_W-1:0];
        REG_MIN_VALID:   min_valid_r <= cfg_wdata[RANGE_W-1:0];
        REG_CRUISE:      cruise_r    <= cfg_wdata[SPEED_W-1:0];
        REG_FALLBACK:    fallback_r  <= cfg_wdata[SPEED_W-1:0];
        REG_TURN_RATE:   turn_r      <= cfg_wdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Scan position and running minimums
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]   idx_r;
  logic [RANGE_W-1:0] min_l_r, min_f_r, min_r_r;
  logic [SIZE_W-1:0]  idx_ext;
  logic               scan_end, in_fire;
  logic               in_left, in_front, in_right, sample_ok;

  assign idx_ext   = SIZE_W'(idx_r);
  assign scan_end  = (idx_ext >= last_r);
  assign in_left   = (idx_ext <= lim_r);
  assign in_front  = (idx_ext >= lim_r) && (idx_ext < rlim_r);
  assign in_right  = (idx_ext >= rlim_r);
  assign sample_ok = (in_tdata > min_valid_r);

  // Only the last sample of a scan needs room in the result register.
  assign in_tready = !out_tvalid || out_tready || !scan_end;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      min_l_r <= NO_RANGE;
      min_f_r <= NO_RANGE;
      min_r_r <= NO_RANGE;
    end else if (in_fire) begin
      if (scan_end) begin
        idx_r   <= '0;
        min_l_r <= NO_RANGE;
        min_f_r <= NO_RANGE;
        min_r_r <= NO_RANGE;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
        if (in_left && sample_ok && in_tdata < min_l_r) begin
          min_l_r <= in_tdata;
        end
        if (in_front && sample_ok && in_tdata < min_f_r) begin
          min_f_r <= in_tdata;
        end
        if (in_right && sample_ok && in_tdata < min_r_r) begin
          min_r_r <= in_tdata;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Decision table on the finished minimums
  // ---------------------------------------------------------------------
  logic               obs_f, obs_l, obs_r;
  case_code_t         code_nxt;
  logic [SPEED_W-1:0] lin_nxt;
  logic [ANG_W-1:0]   ang_nxt;

  assign obs_f = (min_f_r < obstacle_r);
  assign obs_l = (min_l_r < obstacle_r);
  assign obs_r = (min_r_r < obstacle_r);

  always_comb begin
    unique case ({obs_f, obs_l, obs_r})
      3'b000: begin
        code_nxt = CASE_CLEAR;
        lin_nxt  = cruise_r;
        ang_nxt  = '0;
      end
      3'b100: begin
        code_nxt = CASE_FRONT;
        lin_nxt  = '0;
        ang_nxt  = ANG_W'(turn_r);
      end
      3'b110: begin
        code_nxt = CASE_FRONT_LEFT;
        lin_nxt  = '0;
        ang_nxt  = ANG_W'(1'b0) - ANG_W'(turn_r);
      end
      3'b101: begin
        code_nxt = CASE_FRONT_RIGHT;
        lin_nxt  = '0;
        ang_nxt  = ANG_W'(turn_r);
      end
      3'b011: begin
        code_nxt = CASE_BOTH_BACK;
        lin_nxt  = cruise_r;
        ang_nxt  = '0;
      end
      default: begin
        code_nxt = CASE_OTHER;
        lin_nxt  = fallback_r;
        ang_nxt  = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic               out_valid_r;
  logic [SPEED_W-1:0] lin_r;
  logic [ANG_W-1:0]   ang_r;
  case_code_t         code_r;
  logic [RANGE_W-1:0] res_l_r, res_f_r, res_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && scan_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && scan_end) begin
      lin_r   <= lin_nxt;
      ang_r   <= ang_nxt;
      code_r  <= code_nxt;
      res_l_r <= min_l_r;
      res_f_r <= min_f_r;
      res_r_r <= min_r_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r_r, res_f_r, res_l_r, code_r, ang_r, lin_r};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_new_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && scan_end |=> idx_r == '0 && min_l_r == NO_RANGE
                            && min_f_r == NO_RANGE && min_r_r == NO_RANGE)
    else $error("scan state not restarted after last sample");

  a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
    min_l_r <= NO_RANGE && min_f_r <= NO_RANGE && min_r_r <= NO_RANGE)
    else $error("running minimum above start value");

  a_load_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && scan_end))
    else $error("result loaded without a last sample");

  a_turn_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (code_r == CASE_FRONT || code_r == CASE_FRONT_LEFT
                    || code_r == CASE_FRONT_RIGHT) |-> lin_r == '0)
    else $error("forward speed nonzero while turning away");

endmodule
